@@ rtl/sct_pkg.sv @@
// Shared types, codes and helpers of the sequence completion tracker.
package sct_pkg;

  localparam int FieldW   = 48;
  localparam int ModeW    = 2;
  localparam int StatusW  = 2;
  localparam int InDataW  = 48;
  localparam int OutDataW = 152;
  localparam int WordBits = 64;
  localparam int WordLsb  = 6;

  localparam logic [ModeW-1:0] MODE_START    = 2'd0;
  localparam logic [ModeW-1:0] MODE_COMPLETE = 2'd1;
  localparam logic [ModeW-1:0] MODE_CHECK    = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NEVER = 2'd2;
  localparam logic [StatusW-1:0] STATUS_TWICE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MOD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_OLDEST,
    S_TRIM,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    LK_DONE,
    LK_READ,
    LK_NEW
  } look_e;

  // Index of the lowest set bit of a nonzero word, by halving search.
  function automatic logic [WordLsb-1:0] low_bit(input logic [WordBits-1:0] v);
    logic [WordBits-1:0] x;
    logic [WordLsb-1:0]  n;
    x = v;
    n = '0;
    if (x[31:0] == 32'd0) begin
      n[5] = 1'b1;
      x = x >> 32;
    end
    if (x[15:0] == 16'd0) begin
      n[4] = 1'b1;
      x = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      n[3] = 1'b1;
      x = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      n[2] = 1'b1;
      x = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      n[1] = 1'b1;
      x = x >> 2;
    end
    if (x[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

@@ rtl/sequence_completion_tracker.sv @@
// Top level of the sequence completion tracker: sequencer and window state.
//
// Usage: each input beat carries a mode in tuser (start, complete, check) and
// a sequence number in tdata. Start hands out the next number; complete clears
// its outstanding bit; check reports whether a number has completed. Every
// result beat carries the issued number, the check answer, the newest issued
// number, the oldest outstanding number and a status code in tuser.
// The window holds WORDS bitmap words of 64 numbers each in a small memory.
// One item is worked on at a time: s_axis_tready_o is high only while idle.
// Each item goes through S_LOOK, S_MOD unless it is settled from its number
// alone, a walk of S_SCAN_RD/S_SCAN_CHK over the used words up to the one
// holding the oldest outstanding number, S_OLDEST, S_TRIM when a completion
// moves the window, and S_OUT. The next beat is taken only after a result is
// loaded into the output register.
// The walk reads one bitmap word at a time through the memory read port, and
// all sequence-number additions share one adder.
// Reset clears the issued count, the window and the output valid flag; the
// bitmap memory needs no clearing since a word is written before it is read.
// A stalled receiver holds the result in the output register; the block still
// accepts and works on the next beat, and waits before loading its result.
module sequence_completion_tracker #(
  parameter int WORDS    = 4,
  parameter int SEQ_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [47:0] seq_in
  input  logic [sct_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [1:0] mode
  input  logic [sct_pkg::ModeW-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [47:0] seq_issued, [48] is_completed, [96:49] newest_started,
  // [97] any_started, [145:98] oldest_open, [146] oldest_valid, [151:147] zero
  output logic [sct_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // [1:0] status
  output logic [sct_pkg::StatusW-1:0]    m_axis_tuser_o
);
  import sct_pkg::*;

  localparam int IW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW   = $clog2(WORDS + 1);
  localparam int SUMW = CW + 1;
  localparam int WW   = SEQ_BITS - WordLsb;
  localparam logic [SEQ_BITS-1:0] SeqMax = '1;

  // Ring slot of window word idx.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] idx);
    logic [SUMW-1:0] sum;
    sum = SUMW'(head) + SUMW'(idx);
    if (sum >= SUMW'(WORDS)) begin
      sum = sum - SUMW'(WORDS);
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] to_field(input logic [SEQ_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[FieldW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [ModeW-1:0]    mode_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic [SEQ_BITS-1:0] next_seq_q;
  logic [SEQ_BITS-1:0] base_q;
  logic [IW-1:0]       head_q;
  logic [CW-1:0]       used_q;
  logic [SEQ_BITS-1:0] newest_q;
  logic                any_q;
  logic [SEQ_BITS-1:0] issued_q;
  logic                done_q;
  logic [StatusW-1:0]  status_q;
  logic                do_trim_q;
  logic [IW-1:0]       slot_q;
  logic [WordLsb-1:0]  bit_q;
  logic                new_word_q;
  logic [CW-1:0]       scan_idx_q;
  logic                found_q;
  logic [WordLsb-1:0]  lz_q;
  logic [SEQ_BITS-1:0] oldest_q;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [StatusW-1:0]  m_user_q;

  logic [63:0]         seq_wide;
  logic                in_accept;
  logic                out_free;

  logic [SEQ_BITS-1:0] alu_a;
  logic [SEQ_BITS-1:0] alu_b;
  logic                alu_sub;
  logic [SEQ_BITS-1:0] alu_y;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [WordBits-1:0] ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [WordBits-1:0] ram_rdata;

  logic [WW-1:0]       look_word;
  logic [WW-1:0]       used_ext;
  logic                in_used;
  logic                at_end;
  look_e               look_kind;
  logic [StatusW-1:0]  look_status;
  logic                look_done;
  logic [WordBits-1:0] look_mask;

  logic [WordBits-1:0] mod_mask;
  logic                hit;
  logic [CW-1:0]       drop;
  logic                trim_needed;

  assign seq_wide        = 64'(s_axis_tdata_i[FieldW-1:0]);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  assign mod_mask    = WordBits'(1) << bit_q;
  assign hit         = |(ram_rdata & mod_mask);
  assign drop        = scan_idx_q - CW'(1);
  assign trim_needed = do_trim_q && (scan_idx_q > CW'(1));

  sct_addsub #(
    .W(SEQ_BITS)
  ) u_addsub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_y)
  );

  sct_bitmap #(
    .DEPTH(WORDS),
    .AW   (IW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Operand select of the shared adder.
  always_comb begin
    alu_a   = next_seq_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_LOOK: begin
        alu_a   = (mode_q == MODE_START) ? next_seq_q : seq_q;
        alu_b   = base_q;
        alu_sub = 1'b1;
      end
      S_MOD: begin
        alu_a = next_seq_q;
        alu_b = SEQ_BITS'(1);
      end
      S_OLDEST: begin
        alu_a = base_q;
        alu_b = SEQ_BITS'({scan_idx_q, lz_q});
      end
      S_TRIM: begin
        alu_a = base_q;
        alu_b = SEQ_BITS'({drop, {WordLsb{1'b0}}});
      end
      default: begin
        alu_a = next_seq_q;
      end
    endcase
  end

  // Classify the item from its offset into the window.
  always_comb begin
    look_word   = alu_y[SEQ_BITS-1:WordLsb];
    used_ext    = WW'(used_q);
    in_used     = look_word < used_ext;
    at_end      = (look_word == used_ext) && (used_q < CW'(WORDS));
    look_mask   = WordBits'(1) << alu_y[WordLsb-1:0];
    look_kind   = LK_DONE;
    look_status = STATUS_OK;
    look_done   = 1'b0;
    case (mode_q)
      MODE_START: begin
        if (next_seq_q == SeqMax) begin
          look_status = STATUS_FULL;
        end else if (in_used) begin
          look_kind = LK_READ;
        end else if (at_end) begin
          look_kind = LK_NEW;
        end else begin
          look_status = STATUS_FULL;
        end
      end
      MODE_COMPLETE: begin
        if (seq_q >= next_seq_q) begin
          look_status = STATUS_NEVER;
        end else if (seq_q < base_q) begin
          look_status = STATUS_TWICE;
        end else if (!in_used) begin
          look_status = STATUS_NEVER;
        end else begin
          look_kind = LK_READ;
        end
      end
      MODE_CHECK: begin
        if (seq_q >= next_seq_q) begin
          look_status = STATUS_NEVER;
        end else if (seq_q < base_q) begin
          look_done = 1'b1;
        end else if (!in_used) begin
          look_status = STATUS_NEVER;
        end else begin
          look_kind = LK_READ;
        end
      end
      default: begin
        look_kind = LK_DONE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = (look_kind == LK_DONE) ? S_SCAN_RD : S_MOD;
      end
      S_MOD: begin
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = (scan_idx_q == used_q) ? S_OLDEST : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_d = (|ram_rdata) ? S_OLDEST : S_SCAN_RD;
      end
      S_OLDEST: begin
        state_d = trim_needed ? S_TRIM : S_OUT;
      end
      S_TRIM: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = ram_rdata | mod_mask;
    ram_raddr = slot_of(head_q, scan_idx_q);
    case (state_q)
      S_LOOK: begin
        ram_raddr = slot_of(head_q, look_word[CW-1:0]);
        if (look_kind == LK_NEW) begin
          ram_we    = 1'b1;
          ram_waddr = slot_of(head_q, used_q);
          ram_wdata = look_mask;
        end
      end
      S_MOD: begin
        if (mode_q == MODE_START && !new_word_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | mod_mask;
        end else if (mode_q == MODE_COMPLETE && hit) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~mod_mask;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Window and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      next_seq_q <= '0;
      base_q     <= '0;
      head_q     <= '0;
      used_q     <= '0;
      newest_q   <= '0;
      any_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOOK && look_kind == LK_NEW) begin
        used_q <= used_q + CW'(1);
      end
      if (state_q == S_MOD && mode_q == MODE_START) begin
        next_seq_q <= alu_y;
        newest_q   <= next_seq_q;
        any_q      <= 1'b1;
      end
      if (state_q == S_TRIM) begin
        base_q <= alu_y;
        head_q <= slot_of(head_q, drop);
        used_q <= used_q - drop;
      end
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Per-item working registers and output payload.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          mode_q    <= s_axis_tuser_i;
          seq_q     <= seq_wide[SEQ_BITS-1:0];
          issued_q  <= '0;
          done_q    <= 1'b0;
          status_q  <= STATUS_OK;
          do_trim_q <= 1'b0;
          found_q   <= 1'b0;
        end
      end
      S_LOOK: begin
        status_q   <= look_status;
        done_q     <= look_done;
        slot_q     <= ram_raddr;
        bit_q      <= alu_y[WordLsb-1:0];
        new_word_q <= (look_kind == LK_NEW);
        scan_idx_q <= '0;
      end
      S_MOD: begin
        if (mode_q == MODE_START) begin
          issued_q <= next_seq_q;
        end else if (mode_q == MODE_COMPLETE) begin
          if (hit) do_trim_q <= 1'b1;
          else status_q <= STATUS_TWICE;
        end else if (mode_q == MODE_CHECK) begin
          done_q <= !hit;
        end
      end
      S_SCAN_CHK: begin
        if (|ram_rdata) begin
          found_q <= 1'b1;
          lz_q    <= low_bit(ram_rdata);
        end else begin
          scan_idx_q <= scan_idx_q + CW'(1);
        end
      end
      S_OLDEST: begin
        oldest_q <= found_q ? alu_y : '0;
      end
      S_OUT: begin
        if (out_free) begin
          m_data_q <= {5'd0, found_q, to_field(oldest_q), any_q, to_field(newest_q),
                       done_q, to_field(issued_q)};
          m_user_q <= status_q;
        end
      end
      default: begin
        found_q <= found_q;
      end
    endcase
  end

endmodule

@@ rtl/sct_bitmap.sv @@
// Bitmap word memory: one write port, one registered read port.
module sct_bitmap #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [sct_pkg::WordBits-1:0]  wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [sct_pkg::WordBits-1:0]  rdata_o
);
  import sct_pkg::*;

  logic [WordBits-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/sct_addsub.sv @@
// Shared adder/subtractor for offsets, increments, oldest numbers and window moves.
module sct_addsub #(
  parameter int W = 48
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o
);
  import sct_pkg::*;

  logic [W-1:0] b_sel;

  assign b_sel = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_sel + W'(sub_i);

endmodule

@@ tb/sv/tb_sequence_completion_tracker.sv @@
`timescale 1ns / 1ps
// Self-checking testbench: drives start/complete/check and unused-mode beats and compares every result beat.
module tb_sequence_completion_tracker;
  import sct_pkg::*;

  localparam int Words      = 4;
  localparam int SeqBits    = 48;
  localparam int WatchLimit = 2000;
  localparam int PhaseItems = 400;
  localparam int DrainWait  = 20;
  localparam logic [ModeW-1:0]  ModeUnused = 2'd3;
  localparam logic [FieldW-1:0] SeqMask    = {FieldW{1'b1}};

  typedef struct packed {
    logic [FieldW-1:0]  seq_issued;
    logic               is_completed;
    logic [FieldW-1:0]  newest_started;
    logic               any_started;
    logic [FieldW-1:0]  oldest_open;
    logic               oldest_valid;
    logic [StatusW-1:0] status;
  } track_res_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [FieldW-1:0] seq;
    logic              known;
    track_res_t        res;
  } dir_row_t;

  localparam track_res_t NoRes = '0;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [ModeW-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  // Predictor state of the sequence window
  logic [FieldW-1:0]   nxt_seq = '0;
  logic [FieldW-1:0]   win_base = '0;
  logic [WordBits-1:0] win_bits [Words];
  int unsigned         head_slot = 0;
  int unsigned         used_words = 0;
  logic [FieldW-1:0]   open_seqs [$];

  track_res_t          reply_q [$];
  logic [StatusW-1:0]  last_status;
  int                  mismatches = 0;
  int                  send_idle_pct = 25;
  int                  recv_idle_pct = 63;
  int                  quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  sequence_completion_tracker #(
    .WORDS    (Words),
    .SEQ_BITS (SeqBits)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  function automatic int unsigned slot_of(input int unsigned i);
    return (head_slot + i) % Words;
  endfunction

  // Apply one operation to the window and return the reply it produces.
  function automatic track_res_t apply_seq_op(input logic [ModeW-1:0]  mode,
                                              input logic [FieldW-1:0] seq_raw);
    track_res_t          r;
    logic [FieldW-1:0]   seq;
    logic [FieldW-1:0]   off;
    logic [FieldW-1:0]   wi;
    logic [WordBits-1:0] v;
    int unsigned         slot;
    int unsigned         zeroes;
    int unsigned         drop;
    int                  idx;
    int                  b;
    r = '0;
    seq = seq_raw & SeqMask;
    case (mode)
      MODE_START: begin
        off = nxt_seq - win_base;
        wi = off >> WordLsb;
        if (nxt_seq == SeqMask || wi > used_words ||
            (wi == used_words && used_words == Words)) begin
          r.status = STATUS_FULL;
        end else begin
          slot = slot_of(wi[31:0]);
          if (wi == used_words) begin
            win_bits[slot] = '0;
            used_words++;
          end
          win_bits[slot][off[WordLsb-1:0]] = 1'b1;
          r.seq_issued = nxt_seq;
          open_seqs.push_back(nxt_seq);
          nxt_seq = nxt_seq + 1'b1;
        end
      end
      MODE_COMPLETE, MODE_CHECK: begin
        off = seq - win_base;
        wi = off >> WordLsb;
        if (seq >= nxt_seq) begin
          r.status = STATUS_NEVER;
        end else if (seq < win_base) begin
          // below the window counts as done
          if (mode == MODE_COMPLETE) r.status = STATUS_TWICE;
          else r.is_completed = 1'b1;
        end else if (wi >= used_words) begin
          r.status = STATUS_NEVER;
        end else begin
          slot = slot_of(wi[31:0]);
          if (mode == MODE_CHECK) begin
            r.is_completed = !win_bits[slot][off[WordLsb-1:0]];
          end else if (!win_bits[slot][off[WordLsb-1:0]]) begin
            r.status = STATUS_TWICE;
          end else begin
            win_bits[slot][off[WordLsb-1:0]] = 1'b0;
            idx = -1;
            foreach (open_seqs[k]) if (open_seqs[k] == seq) idx = k;
            if (idx >= 0) open_seqs.delete(idx);
            // drop leading clear words but keep one in front
            zeroes = 0;
            while (zeroes < used_words && win_bits[slot_of(zeroes)] == '0) zeroes++;
            if (zeroes > 1) begin
              drop = zeroes - 1;
              head_slot = slot_of(drop);
              used_words = used_words - drop;
              win_base = win_base + drop * WordBits;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < used_words && !r.oldest_valid; i++) begin
      v = win_bits[slot_of(i)];
      if (v != '0) begin
        for (b = WordBits - 1; b >= 0; b--) if (v[b]) off = FieldW'(b);
        r.oldest_open = win_base + i * WordBits + off;
        r.oldest_valid = 1'b1;
      end
    end
    r.any_started = (nxt_seq != '0);
    r.newest_started = r.any_started ? nxt_seq - 1'b1 : '0;
    return r;
  endfunction

  // Offer one beat, idling first at random, and predict its reply on acceptance.
  task automatic drive_item(input logic [ModeW-1:0] mode, input logic [FieldW-1:0] seq,
                            input logic known, input track_res_t typed_res);
    track_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seq;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_seq_op(mode, seq);
    last_status = r.status;
    reply_q.push_back(known ? typed_res : r);
  endtask

  // Choose the next random operation from the current window contents.
  task automatic pick_item(input bit fill, output logic [ModeW-1:0] mode,
                           output logic [FieldW-1:0] seq);
    int roll;
    int hi;
    roll = $urandom_range(0, 99);
    seq = FieldW'({$urandom, $urandom});
    if (roll < (fill ? 85 : 45)) begin
      mode = MODE_START;
    end else if (!fill && roll < 83 && open_seqs.size() != 0) begin
      mode = MODE_COMPLETE;
      hi = (open_seqs.size() > 8) ? 7 : open_seqs.size() - 1;
      if ($urandom_range(0, 3) != 0) seq = open_seqs[$urandom_range(0, hi)];
      else seq = open_seqs[$urandom_range(0, open_seqs.size() - 1)];
    end else if (roll < 95) begin
      mode = MODE_CHECK;
      if (open_seqs.size() != 0 && $urandom_range(0, 4) < 2)
        seq = open_seqs[$urandom_range(0, open_seqs.size() - 1)];
      else
        seq = FieldW'($urandom_range(0, nxt_seq[31:0] + 2));
    end else begin
      case ($urandom_range(0, 3))
        0: mode = ModeUnused;
        1: mode = MODE_COMPLETE;
        2: begin
          mode = MODE_COMPLETE;
          seq = FieldW'($urandom_range(0, nxt_seq[31:0]));
        end
        default: mode = MODE_CHECK;
      endcase
    end
  endtask

  task automatic cmp_field(input string name, input logic [FieldW-1:0] got,
                           input logic [FieldW-1:0] want);
    if (got !== want) begin
      if (mismatches < 10) $display("mismatch %s: expected %h got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : rx_side
    track_res_t got;
    track_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.seq_issued     = m_axis_tdata[47:0];
      got.is_completed   = m_axis_tdata[48];
      got.newest_started = m_axis_tdata[96:49];
      got.any_started    = m_axis_tdata[97];
      got.oldest_open    = m_axis_tdata[145:98];
      got.oldest_valid   = m_axis_tdata[146];
      got.status         = m_axis_tuser;
      if (reply_q.size() == 0) begin
        if (mismatches < 10) $display("result beat with nothing pending: %h", got);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        cmp_field("seq_issued", got.seq_issued, want.seq_issued);
        cmp_field("is_completed", FieldW'(got.is_completed), FieldW'(want.is_completed));
        cmp_field("newest_started", got.newest_started, want.newest_started);
        cmp_field("any_started", FieldW'(got.any_started), FieldW'(want.any_started));
        cmp_field("oldest_open", got.oldest_open, want.oldest_open);
        cmp_field("oldest_valid", FieldW'(got.oldest_valid), FieldW'(want.oldest_valid));
        cmp_field("status", FieldW'(got.status), FieldW'(want.status));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t          dir_rows [$];
    logic [ModeW-1:0]  mode;
    logic [FieldW-1:0] seq;
    int                n_items;
    int                full_hits;

    for (int i = 0; i < Words; i++) win_bits[i] = '0;

    // mode, seq_in, typed-in reply, reply
    dir_rows.push_back({MODE_CHECK, 48'd0, 1'b1,
                        {48'd0, 1'b0, 48'd0, 1'b0, 48'd0, 1'b0, STATUS_NEVER}});
    dir_rows.push_back({MODE_COMPLETE, 48'hFFFF_FFFF_FFFF, 1'b1,
                        {48'd0, 1'b0, 48'd0, 1'b0, 48'd0, 1'b0, STATUS_NEVER}});
    dir_rows.push_back({ModeUnused, 48'hAAAA_AAAA_AAAA, 1'b1,
                        {48'd0, 1'b0, 48'd0, 1'b0, 48'd0, 1'b0, STATUS_OK}});
    dir_rows.push_back({MODE_START, 48'd0, 1'b1,
                        {48'd0, 1'b0, 48'd0, 1'b1, 48'd0, 1'b1, STATUS_OK}});
    dir_rows.push_back({MODE_START, 48'hFFFF_FFFF_FFFF, 1'b1,
                        {48'd1, 1'b0, 48'd1, 1'b1, 48'd0, 1'b1, STATUS_OK}});
    dir_rows.push_back({MODE_COMPLETE, 48'd0, 1'b1,
                        {48'd0, 1'b0, 48'd1, 1'b1, 48'd1, 1'b1, STATUS_OK}});
    dir_rows.push_back({MODE_COMPLETE, 48'd0, 1'b1,
                        {48'd0, 1'b0, 48'd1, 1'b1, 48'd1, 1'b1, STATUS_TWICE}});
    dir_rows.push_back({MODE_CHECK, 48'd0, 1'b1,
                        {48'd0, 1'b1, 48'd1, 1'b1, 48'd1, 1'b1, STATUS_OK}});
    dir_rows.push_back({MODE_CHECK, 48'd1, 1'b1,
                        {48'd0, 1'b0, 48'd1, 1'b1, 48'd1, 1'b1, STATUS_OK}});
    dir_rows.push_back({MODE_CHECK, 48'd2, 1'b1,
                        {48'd0, 1'b0, 48'd1, 1'b1, 48'd1, 1'b1, STATUS_NEVER}});
    dir_rows.push_back({MODE_COMPLETE, 48'd1, 1'b1,
                        {48'd0, 1'b0, 48'd1, 1'b1, 48'd0, 1'b0, STATUS_OK}});
    dir_rows.push_back({MODE_CHECK, 48'h5555_5555_5555, 1'b1,
                        {48'd0, 1'b0, 48'd1, 1'b1, 48'd0, 1'b0, STATUS_NEVER}});
    for (int i = 0; i < 8; i++)
      dir_rows.push_back({MODE_START, (i[0] ? 48'h5555_5555_5555 : 48'hAAAA_AAAA_AAAA),
                          1'b0, NoRes});
    dir_rows.push_back({MODE_COMPLETE, 48'd5, 1'b0, NoRes});
    dir_rows.push_back({MODE_CHECK, 48'd5, 1'b0, NoRes});
    dir_rows.push_back({MODE_COMPLETE, 48'd2, 1'b0, NoRes});
    dir_rows.push_back({ModeUnused, 48'h5555_5555_5555, 1'b0, NoRes});
    dir_rows.push_back({MODE_COMPLETE, 48'd9, 1'b0, NoRes});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k])
      drive_item(dir_rows[k].mode, dir_rows[k].seq, dir_rows[k].known, dir_rows[k].res);

    n_items = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 25 : 0;
      // in the first two phases push the window to full three times, then slide it with mixed traffic
      full_hits = (ph < 2) ? 0 : 3;
      while (full_hits < 3) begin
        pick_item(1'b1, mode, seq);
        drive_item(mode, seq, 1'b0, NoRes);
        if (mode == MODE_START && last_status == STATUS_FULL) full_hits++;
        if (mode != ModeUnused) n_items++;
      end
      while (n_items < PhaseItems * (ph + 1)) begin
        pick_item(1'b0, mode, seq);
        drive_item(mode, seq, 1'b0, NoRes);
        if (mode != ModeUnused) n_items++;
      end
      // hold off until every reply is back
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (reply_q.size() != 0);
    end

    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
